// ===== sv/tcpp_pkg.sv =====
// ----------------------------------------------------------------------------
// tcpp_pkg: shared types and constants of the text coordinate plot parser
// Byte codes, token phases, result status codes and register indexes.
// ----------------------------------------------------------------------------
package tcpp_pkg;

	// Largest coordinate magnitude plus one; magnitudes saturate here.
	localparam int MAX_DIM = 4096;
	localparam int MAG_W   = 13;
	localparam int DIM_W   = 13;
	localparam int COORD_W = 12;
	localparam int ADDR_W  = 24;

	localparam logic [DIM_W-1:0] DIM_CAP = DIM_W'(MAX_DIM);

	localparam logic [7:0] CH_NUL   = 8'd0;
	localparam logic [7:0] CH_NL    = 8'd10;
	localparam logic [7:0] CH_PLUS  = 8'd43;
	localparam logic [7:0] CH_MINUS = 8'd45;
	localparam logic [7:0] CH_DOT   = 8'd46;
	localparam logic [7:0] CH_0     = 8'd48;
	localparam logic [7:0] CH_9     = 8'd57;

	typedef enum logic [1:0] {
		PH_SIGN   = 2'd0,
		PH_DIGITS = 2'd1,
		PH_DONE   = 2'd2
	} phase_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_X_MISSING = 3'd1,
		ST_X_RANGE   = 3'd2,
		ST_Y_MISSING = 3'd3,
		ST_Y_RANGE   = 3'd4
	} status_t;

	typedef enum logic {
		REG_WIDTH  = 1'b0,
		REG_HEIGHT = 1'b1
	} reg_idx_t;

endpackage

// ===== sv/text_coordinate_plot_parser_top.sv =====
// ----------------------------------------------------------------------------
// text_coordinate_plot_parser_top: line parser for "x y" text coordinates
// Takes one text byte per request, reads the first two integer tokens of each
// line and emits status, x, y and pixel address on every newline.
// ----------------------------------------------------------------------------
//
// Channel   | Handshake                  | Payload
// ----------+----------------------------+----------------------------------
// text      | text_valid / text_ready    | text_byte
// result    | result_valid / result_ready| line_status, coord_x, coord_y,
//           |                            | pixel_address
// config    | APB psel/penable/pwrite    | paddr, pwdata, prdata
//
// One byte is taken per cycle while text_ready is high. A newline moves its
// result into stage one and then, once the output stage is free, into the
// output register where the row multiply lands; result_valid rises when the
// result reaches the output register.
// text_ready drops only while both stages hold results and result_ready is low.
// Reset clears the line state and loads both dimension registers with 1000.
// No clearing pass is needed after reset.

module text_coordinate_plot_parser_top
	import tcpp_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,

	input  logic               text_valid,
	output logic               text_ready,
	input  logic [7:0]         text_byte,

	output logic               result_valid,
	input  logic               result_ready,
	output logic [2:0]         line_status,
	output logic [COORD_W-1:0] coord_x,
	output logic [COORD_W-1:0] coord_y,
	output logic [ADDR_W-1:0]  pixel_address,

	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	// Configuration registers.
	logic [DIM_W-1:0] width_q, height_q;
	logic             cfg_wr;
	reg_idx_t         cfg_idx;

	// Line state.
	logic [1:0]       count_q, count_d;
	logic             inside_q, inside_d;
	phase_t           phase_q, phase_d;
	logic             neg_q, neg_d;
	logic [MAG_W-1:0] mag_q, mag_d;
	logic [MAG_W-1:0] first_q, first_d;
	logic             first_bad_q, first_bad_d;
	logic             voided_q, voided_d;

	// Stage one and output stage.
	logic               valid_s1;
	status_t            status_s1;
	logic [COORD_W-1:0] x_s1, y_s1;
	logic [DIM_W-1:0]   w_s1;
	logic               valid_s2;
	status_t            status_s2;
	logic [COORD_W-1:0] x_s2, y_s2;
	logic [ADDR_W-1:0]  addr_s2;

	logic             accept, nl_accept, s2_free, s1_adv;
	logic [DIM_W-1:0] w_eff, h_eff;
	logic [MAG_W-1:0] fin_first;
	logic             fin_first_bad;
	status_t          status_c;

	// ------------------------------------------------------------------
	// Configuration port
	// ------------------------------------------------------------------
	assign pready  = 1'b1;
	assign cfg_idx = reg_idx_t'(paddr[2]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DIM_W'(1000);
			height_q <= DIM_W'(1000);
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_WIDTH:  width_q  <= pwdata[DIM_W-1:0];
				REG_HEIGHT: height_q <= pwdata[DIM_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			REG_WIDTH:  prdata = {{(32-DIM_W){1'b0}}, width_q};
			REG_HEIGHT: prdata = {{(32-DIM_W){1'b0}}, height_q};
			default:    prdata = '0;
		endcase
	end

	assign w_eff = (width_q  > DIM_CAP) ? DIM_CAP : width_q;
	assign h_eff = (height_q > DIM_CAP) ? DIM_CAP : height_q;

	// ------------------------------------------------------------------
	// Flow control
	// ------------------------------------------------------------------
	assign s2_free    = !valid_s2 || result_ready;
	assign s1_adv     = valid_s1 && s2_free;
	assign text_ready = !valid_s1 || s2_free;
	assign accept     = text_valid && text_ready;
	assign nl_accept  = accept && (text_byte == CH_NL);

	// ------------------------------------------------------------------
	// Token scanner
	// ------------------------------------------------------------------
	// A token in progress closes into the first value when it is the first.
	assign fin_first     = (inside_q && count_q == 2'd1) ? mag_q : first_q;
	assign fin_first_bad = (inside_q && count_q == 2'd1) ? (neg_q && mag_q != '0)
	                                                     : first_bad_q;

	always_comb begin
		logic             is_digit;
		logic             is_tok;
		phase_t           ph;
		logic [MAG_W-1:0] mg;
		logic [16:0]      prod;

		is_digit = text_byte inside {[CH_0:CH_9]};
		is_tok   = is_digit || (text_byte inside {CH_DOT, CH_MINUS, CH_PLUS});
		ph       = phase_q;
		mg       = mag_q;
		prod     = '0;

		count_d     = count_q;
		inside_d    = inside_q;
		phase_d     = phase_q;
		neg_d       = neg_q;
		mag_d       = mag_q;
		first_d     = first_q;
		first_bad_d = first_bad_q;
		voided_d    = voided_q;

		if (text_byte == CH_NL) begin
			count_d     = '0;
			inside_d    = 1'b0;
			phase_d     = PH_SIGN;
			neg_d       = 1'b0;
			mag_d       = '0;
			first_d     = '0;
			first_bad_d = 1'b0;
			voided_d    = 1'b0;
		end else if (!voided_q) begin
			if (text_byte == CH_NUL || !is_tok) begin
				first_d     = fin_first;
				first_bad_d = fin_first_bad;
				inside_d    = 1'b0;
				if (text_byte == CH_NUL) begin
					voided_d = 1'b1;
				end
			end else if (inside_q || count_q < 2'd2) begin
				if (!inside_q) begin
					count_d  = count_q + 2'd1;
					inside_d = 1'b1;
					ph       = PH_SIGN;
					mg       = '0;
					neg_d    = 1'b0;
				end
				phase_d = ph;
				mag_d   = mg;
				if (is_digit) begin
					if (ph != PH_DONE) begin
						prod = {1'b0, mg, 3'b000} + {3'b000, mg, 1'b0}
						     + {13'd0, text_byte[3:0]};
						mag_d   = (prod > 17'(MAX_DIM)) ? MAG_W'(MAX_DIM) : prod[MAG_W-1:0];
						phase_d = PH_DIGITS;
					end
				end else if ((text_byte == CH_MINUS || text_byte == CH_PLUS)
				             && ph == PH_SIGN) begin
					neg_d   = (text_byte == CH_MINUS);
					phase_d = PH_DIGITS;
				end else begin
					phase_d = PH_DONE;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			inside_q    <= 1'b0;
			phase_q     <= PH_SIGN;
			neg_q       <= 1'b0;
			mag_q       <= '0;
			first_q     <= '0;
			first_bad_q <= 1'b0;
			voided_q    <= 1'b0;
		end else if (accept) begin
			count_q     <= count_d;
			inside_q    <= inside_d;
			phase_q     <= phase_d;
			neg_q       <= neg_d;
			mag_q       <= mag_d;
			first_q     <= first_d;
			first_bad_q <= first_bad_d;
			voided_q    <= voided_d;
		end
	end

	// ------------------------------------------------------------------
	// Line verdict; the first failing check wins.
	// ------------------------------------------------------------------
	always_comb begin
		logic x_ok, y_ok;
		x_ok = !fin_first_bad && (fin_first < MAG_W'(w_eff));
		y_ok = !(neg_q && mag_q != '0) && (mag_q < MAG_W'(h_eff));
		if (count_q == 2'd0) begin
			status_c = ST_X_MISSING;
		end else if (!x_ok) begin
			status_c = ST_X_RANGE;
		end else if (count_q < 2'd2) begin
			status_c = ST_Y_MISSING;
		end else if (!y_ok) begin
			status_c = ST_Y_RANGE;
		end else begin
			status_c = ST_OK;
		end
	end

	// ------------------------------------------------------------------
	// Stage one: verdict and coordinates
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (nl_accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (nl_accept) begin
			status_s1 <= status_c;
			x_s1      <= (status_c == ST_OK) ? fin_first[COORD_W-1:0] : '0;
			y_s1      <= (status_c == ST_OK) ? mag_q[COORD_W-1:0] : '0;
			w_s1      <= w_eff;
		end
	end

	// ------------------------------------------------------------------
	// Output stage: row address multiply
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s1_adv) begin
			valid_s2 <= 1'b1;
		end else if (result_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			status_s2 <= status_s1;
			x_s2      <= x_s1;
			y_s2      <= y_s1;
			addr_s2   <= ADDR_W'(y_s1) * ADDR_W'(w_s1) + ADDR_W'(x_s1);
		end
	end

	assign result_valid  = valid_s2;
	assign line_status   = status_s2;
	assign coord_x       = x_s2;
	assign coord_y       = y_s2;
	assign pixel_address = addr_s2;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	a_nl_loads_s1: assert property (@(posedge clk) disable iff (!arst_n)
		nl_accept |=> valid_s1)
		else $error("newline request did not reach stage one");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!text_ready |-> (valid_s1 && valid_s2 && !result_ready))
		else $error("text stalled without a full pipeline");

	a_fail_zeroes: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && line_status != ST_OK)
		|-> (coord_x == '0 && coord_y == '0 && pixel_address == '0))
		else $error("failed line carries nonzero coordinates");

	a_s1_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && s2_free && !nl_accept) |=> (valid_s2 && !valid_s1))
		else $error("stage one did not move to the output stage");

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the text coordinate plot parser
// Streams text lines with random handshake gaps and stalls, predicts each
// newline's status, x, y and pixel address, and checks every result in order.
// ----------------------------------------------------------------------------

module tb_top;
	import tcpp_pkg::*;

	localparam int QUIET_LIMIT = 2000;

	typedef struct packed {
		status_t             status;
		logic [COORD_W-1:0]  x;
		logic [COORD_W-1:0]  y;
		logic [ADDR_W-1:0]   addr;
	} point_t;

	// Tracks the line parser state and the points each newline should produce.
	class point_tracker;
		logic [DIM_W-1:0] width_reg;
		logic [DIM_W-1:0] height_reg;
		logic [1:0]       tok_count;
		bit               in_tok;
		phase_t           phase;
		bit               tok_neg;
		logic [MAG_W-1:0] tok_mag;
		logic [MAG_W-1:0] first_mag;
		bit               first_bad;
		bit               voided;
		point_t           points_due[$];
		int               fail_count;

		function new();
			fail_count = 0;
			width_reg = 13'd1000;
			height_reg = 13'd1000;
			clear_line();
		endfunction

		function void clear_line();
			tok_count = 2'd0;
			in_tok = 1'b0;
			phase = PH_SIGN;
			tok_neg = 1'b0;
			tok_mag = '0;
			first_mag = '0;
			first_bad = 1'b0;
			voided = 1'b0;
		endfunction

		function void close_token();
			if (in_tok && tok_count == 2'd1) begin
				first_mag = tok_mag;
				first_bad = tok_neg && tok_mag != 0;
			end
			in_tok = 1'b0;
		endfunction

		function void set_dim(reg_idx_t idx, logic [DIM_W-1:0] val);
			if (idx == REG_WIDTH)
				width_reg = val;
			else
				height_reg = val;
		endfunction

		function logic [DIM_W-1:0] dim_reg(reg_idx_t idx);
			return (idx == REG_WIDTH) ? width_reg : height_reg;
		endfunction

		// Registers above the largest image size act as that size.
		function int eff(reg_idx_t idx);
			int d;
			d = int'(dim_reg(idx));
			return (d > MAX_DIM) ? MAX_DIM : d;
		endfunction

		function bit coord_ok(int v, bit bad, int dim);
			return !bad && v < dim && v < MAX_DIM;
		endfunction

		function int pending();
			return points_due.size();
		endfunction

		function void take_byte(logic [7:0] c);
			int w;
			int h;
			int m;
			point_t due;
			if (c == CH_NL) begin
				w = eff(REG_WIDTH);
				h = eff(REG_HEIGHT);
				close_token();
				due = '{status: ST_OK, x: '0, y: '0, addr: '0};
				if (tok_count == 2'd0)
					due.status = ST_X_MISSING;
				else if (!coord_ok(int'(first_mag), first_bad, w))
					due.status = ST_X_RANGE;
				else if (tok_count < 2'd2)
					due.status = ST_Y_MISSING;
				else if (!coord_ok(int'(tok_mag), tok_neg && tok_mag != 0, h))
					due.status = ST_Y_RANGE;
				else begin
					due.x = COORD_W'(first_mag);
					due.y = COORD_W'(tok_mag);
					due.addr = ADDR_W'(int'(tok_mag) * w + int'(first_mag));
				end
				points_due.push_back(due);
				clear_line();
				return;
			end
			if (voided)
				return;
			if (c == CH_NUL) begin
				close_token();
				voided = 1'b1;
				return;
			end
			if (!((c >= CH_0 && c <= CH_9) || c == CH_DOT || c == CH_MINUS || c == CH_PLUS)) begin
				close_token();
				return;
			end
			if (!in_tok) begin
				if (tok_count >= 2'd2)
					return;
				tok_count++;
				in_tok = 1'b1;
				phase = PH_SIGN;
				tok_neg = 1'b0;
				tok_mag = '0;
			end
			if (c >= CH_0 && c <= CH_9) begin
				if (phase != PH_DONE) begin
					m = int'(tok_mag) * 10 + int'(c) - int'(CH_0);
					tok_mag = MAG_W'((m > MAX_DIM) ? MAX_DIM : m);
					phase = PH_DIGITS;
				end
			end else if ((c == CH_MINUS || c == CH_PLUS) && phase == PH_SIGN) begin
				tok_neg = (c == CH_MINUS);
				phase = PH_DIGITS;
			end else
				phase = PH_DONE;
		endfunction

		task report(string msg);
			$display("ERROR @%0t: %s", $time, msg);
			fail_count++;
		endtask

		task check_point(logic [2:0] st, logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
				logic [ADDR_W-1:0] addr);
			point_t due;
			if (points_due.size() == 0) begin
				report($sformatf("result status %0d with no line pending", st));
				return;
			end
			due = points_due.pop_front();
			if (st !== due.status)
				report($sformatf("line_status %0d, want %0d", st, due.status));
			if (x !== due.x)
				report($sformatf("coord_x %0d, want %0d", x, due.x));
			if (y !== due.y)
				report($sformatf("coord_y %0d, want %0d", y, due.y));
			if (addr !== due.addr)
				report($sformatf("pixel_address %0d, want %0d", addr, due.addr));
		endtask
	endclass

	logic               clk;
	logic               arst_n = 1'b0;
	logic               text_valid = 1'b0;
	logic               text_ready;
	logic [7:0]         text_byte = 8'd0;
	logic               result_valid;
	logic               result_ready = 1'b0;
	logic [2:0]         line_status;
	logic [COORD_W-1:0] coord_x;
	logic [COORD_W-1:0] coord_y;
	logic [ADDR_W-1:0]  pixel_address;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [2:0]         paddr = 3'd0;
	logic [31:0]        pwdata = 32'd0;
	logic [31:0]        prdata;
	logic               pready;

	point_tracker points;
	bit           steady = 1'b0;
	int           ready_hold = 0;
	logic [7:0]   line_bytes[$];

	text_coordinate_plot_parser_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.text_valid    (text_valid),
		.text_ready    (text_ready),
		.text_byte     (text_byte),
		.result_valid  (result_valid),
		.result_ready  (result_ready),
		.line_status   (line_status),
		.coord_x       (coord_x),
		.coord_y       (coord_y),
		.pixel_address (pixel_address),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (text_valid && text_ready)
				points.take_byte(text_byte);
			if (result_valid && result_ready)
				points.check_point(line_status, coord_x, coord_y, pixel_address);
		end
	end

	// Mostly short stalls on the result side, now and then a long one.
	always @(posedge clk) begin : result_stall
		int roll;
		roll = $urandom_range(0, 99);
		if (ready_hold > 0)
			ready_hold <= ready_hold - 1;
		else if (steady)
			result_ready <= 1'b1;
		else if (roll < 65) begin
			result_ready <= 1'b1;
			ready_hold <= $urandom_range(0, 4);
		end else if (roll < 95) begin
			result_ready <= 1'b0;
			ready_hold <= $urandom_range(0, 3);
		end else begin
			result_ready <= 1'b0;
			ready_hold <= $urandom_range(10, 60);
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (text_valid && text_ready) || (result_valid && result_ready)
					|| (psel && penable))
				quiet = 0;
			else
				quiet++;
		end
		$display("text_coordinate_plot_parser_top: mismatch");
		$finish;
	end

	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (steady || roll < 60)
			return 0;
		if (roll < 88)
			return $urandom_range(1, 3);
		if (roll < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 80);
	endfunction

	task automatic send_byte(logic [7:0] b);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			text_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		text_valid <= 1'b1;
		text_byte <= b;
		do @(posedge clk); while (!text_ready);
	endtask

	task automatic send_text(string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i]);
	endtask

	// Results are counted at the falling edge, after the monitor has run.
	task automatic wait_idle();
		text_valid <= 1'b0;
		do @(negedge clk); while (points.pending() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic reg_write(reg_idx_t idx, logic [DIM_W-1:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {19'($urandom_range(0, 32'h7FFFF)), val};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		points.set_dim(idx, val);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic reg_check(reg_idx_t idx);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= {idx, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata !== {19'd0, points.dim_reg(idx)})
			points.report($sformatf("register %s reads %0d, want %0d", idx.name(), prdata,
				points.dim_reg(idx)));
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	function automatic void add_text(string s);
		for (int i = 0; i < s.len(); i++)
			line_bytes.push_back(s[i]);
	endfunction

	function automatic logic [7:0] pick_delim();
		logic [7:0] c;
		case ($urandom_range(0, 4))
			0: c = " ";
			1: c = ",";
			2: c = "|";
			default: begin
				do c = 8'($urandom_range(1, 255));
				while (c == CH_NL || (c >= CH_0 && c <= CH_9) || c == CH_DOT
					|| c == CH_MINUS || c == CH_PLUS);
			end
		endcase
		return c;
	endfunction

	// One number token: mostly in range for the axis, with edges, overflow,
	// signs, leading zeros and junk after the digits mixed in.
	function automatic void add_number(int dim);
		int v;
		int kind;
		int sign_roll;
		kind = $urandom_range(0, 99);
		sign_roll = $urandom_range(0, 99);
		if (dim <= 0)
			v = $urandom_range(0, 20);
		else if (kind < 65)
			v = $urandom_range(0, dim - 1);
		else if (kind < 75)
			v = dim - 1;
		else if (kind < 80)
			v = 0;
		else if (kind < 90)
			v = dim + $urandom_range(0, 3);
		else
			v = $urandom_range(4090, 999999);
		if (sign_roll < 10)
			line_bytes.push_back(CH_MINUS);
		else if (sign_roll < 25)
			line_bytes.push_back(CH_PLUS);
		if (sign_roll < 25 && $urandom_range(0, 9) == 0)
			return;
		if ($urandom_range(0, 9) == 0)
			repeat ($urandom_range(1, 3)) line_bytes.push_back(CH_0);
		add_text($sformatf("%0d", v));
		case ($urandom_range(0, 9))
			0: add_text($sformatf(".%0d", $urandom_range(0, 99)));
			1: add_text($sformatf("%s%0d", ($urandom_range(0, 1) != 0) ? "-" : "+",
				$urandom_range(0, 9)));
			default: ;
		endcase
	endfunction

	function automatic void make_line();
		line_bytes.delete();
		if ($urandom_range(0, 99) < 80) begin
			repeat ($urandom_range(0, 2)) line_bytes.push_back(pick_delim());
			if ($urandom_range(0, 19) != 0)
				add_number(points.eff(REG_WIDTH));
			repeat ($urandom_range(1, 3)) line_bytes.push_back(pick_delim());
			if ($urandom_range(0, 9) != 0)
				add_number(points.eff(REG_HEIGHT));
			if ($urandom_range(0, 4) == 0) begin
				line_bytes.push_back(pick_delim());
				add_number(points.eff(REG_WIDTH));
			end
			if ($urandom_range(0, 9) == 0)
				line_bytes.insert($urandom_range(0, line_bytes.size()), CH_NUL);
			repeat ($urandom_range(0, 1)) line_bytes.push_back(pick_delim());
		end else begin
			repeat ($urandom_range(1, 12)) line_bytes.push_back(8'($urandom_range(0, 255)));
		end
		line_bytes.push_back(CH_NL);
	endfunction

	task automatic run_lines(int budget);
		int sent;
		sent = 0;
		while (sent < budget) begin
			make_line();
			foreach (line_bytes[i])
				send_byte(line_bytes[i]);
			sent += line_bytes.size();
		end
	endtask

	initial begin
		int unsigned widths[8];
		int unsigned heights[8];
		int unsigned w;
		int unsigned h;
		widths = '{1, 4096, 640, 0, 8191, 0, 4095, 1000};
		heights = '{1, 4096, 480, 7, 5000, 0, 2, 1000};
		points = new();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		reg_check(REG_WIDTH);
		reg_check(REG_HEIGHT);

		// Empty line, signed zero and plus, negative x, missing y with a
		// high delimiter byte, saturated y, and a NUL that voids the rest.
		send_text("\n-0 +5\n-3\n7");
		send_byte(8'hFF);
		send_text("\n1|5000\n4 ");
		send_byte(CH_NUL);
		send_text("9\n");

		for (int p = 0; p < 8; p++) begin
			wait_idle();
			w = widths[p];
			h = heights[p];
			if (p == 5) begin
				w = $urandom_range(1, 4096);
				h = $urandom_range(1, 4096);
			end
			reg_write(REG_WIDTH, DIM_W'(w));
			reg_write(REG_HEIGHT, DIM_W'(h));
			reg_check(REG_WIDTH);
			reg_check(REG_HEIGHT);
			steady = (p == 2);
			if (p == 5) begin
				run_lines(100);
				wait_idle();
				run_lines(110);
			end else
				run_lines(210);
		end
		steady = 1'b0;
		// Trailing text with no newline must not produce a result.
		send_text("12 3");
		wait_idle();
		repeat (4) @(posedge clk);
		if (points.fail_count == 0)
			$display("text_coordinate_plot_parser_top: match");
		else
			$display("text_coordinate_plot_parser_top: mismatch");
		$finish;
	end

endmodule
